// File: design/gpe_pkg.sv
// Shared constants, types and a helper function of the GGA position extractor.
package gpe_pkg;

	// Minute fraction digits kept; digits past this are truncated.
	localparam int FRACTION_DIGITS = 5;

	localparam int BYTE_W  = 8;
	localparam int LAT_W   = 32;
	localparam int LON_W   = 35;
	localparam int POS_W   = 4;
	localparam int FIELD_W = 3;
	localparam int DEG_W   = 10;
	localparam int WHOLE_W = 7;
	localparam int FRAC_W  = $clog2(10 ** FRACTION_DIGITS);
	localparam int CNT_W   = $clog2(FRACTION_DIGITS + 1);

	localparam logic [POS_W-1:0]   POS_MAX   = '1;
	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
	localparam logic [WHOLE_W-1:0] WHOLE_MAX = WHOLE_W'(99);

	// Field numbers counted by comma position after the tag.
	localparam logic [FIELD_W-1:0] FLD_LAT = FIELD_W'(2);
	localparam logic [FIELD_W-1:0] FLD_NS  = FIELD_W'(3);
	localparam logic [FIELD_W-1:0] FLD_LON = FIELD_W'(4);
	localparam logic [FIELD_W-1:0] FLD_EW  = FIELD_W'(5);

	localparam logic [POS_W-1:0] LAT_DEG_LEN = POS_W'(2);
	localparam logic [POS_W-1:0] LON_DEG_LEN = POS_W'(3);

	// Characters.
	localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
	localparam logic [BYTE_W-1:0] CH_G     = 8'h47;
	localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
	localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
	localparam logic [BYTE_W-1:0] CH_W     = 8'h57;
	localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

	// Fixed-point arithmetic: units of 1e-7 degree.
	localparam int SCALE_W = 24;
	localparam logic [SCALE_W-1:0] DEG_SCALE = SCALE_W'(10_000_000);
	// Minutes times 1e7 stays below 1e9.
	localparam int NUM_W   = 30;
	localparam int FRACP_W = SCALE_W;
	// Divide by 60 as a shift by two, then multiply by the reciprocal of 15.
	localparam int M_W         = NUM_W - 2;
	localparam int RECIP_W     = 29;
	localparam int RECIP_SHIFT = 32;
	localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(286331154);
	localparam int Q_W = M_W + RECIP_W - RECIP_SHIFT;

	localparam logic signed [LAT_W-1:0] LAT_LIMIT = LAT_W'(1156666665);
	localparam logic signed [LON_W-1:0] LON_LIMIT = LON_W'(64'd10156666665);

	typedef enum logic [2:0] {
		PH_HUNT_P,
		PH_HUNT_G1,
		PH_HUNT_G2,
		PH_HUNT_A,
		PH_COLLECT
	} gpe_phase_t;

	// Raw captured coordinate, before conversion.
	typedef struct packed {
		logic [DEG_W-1:0]   deg;
		logic [WHOLE_W-1:0] whole;
		logic [FRAC_W-1:0]  frac;
		logic [CNT_W-1:0]   cnt;
	} gpe_raw_t;

	// Sentence record handed from the parser at the end mark.
	typedef struct packed {
		gpe_raw_t lat;
		gpe_raw_t lon;
		logic     south;
		logic     west;
	} gpe_rec_t;

	// Load enables of the conversion stages.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} gpe_stage_en_t;

	// 10^(7-cnt): scales the fraction digits to units of 1e-7 minute.
	function automatic logic [FRACP_W-1:0] frac_scale(input logic [CNT_W-1:0] cnt);
		logic [FRACP_W-1:0] v;
		case (int'(cnt))
			0:       v = FRACP_W'(10_000_000);
			1:       v = FRACP_W'(1_000_000);
			2:       v = FRACP_W'(100_000);
			3:       v = FRACP_W'(10_000);
			4:       v = FRACP_W'(1_000);
			5:       v = FRACP_W'(100);
			6:       v = FRACP_W'(10);
			default: v = FRACP_W'(1);
		endcase
		return v;
	endfunction

endpackage

// File: design/gpe_if.sv
// Valid/ready channel interfaces: received bytes in, positions out.
interface gpe_byte_if;
	logic                           valid;
	logic                           ready;
	logic [gpe_pkg::BYTE_W-1:0]     rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gpe_pos_if;
	logic                               valid;
	logic                               ready;
	logic signed [gpe_pkg::LAT_W-1:0]   latitude;
	logic signed [gpe_pkg::LON_W-1:0]   longitude;

	modport source (output valid, output latitude, output longitude, input ready);
	modport sink   (input valid, input latitude, input longitude, output ready);
endinterface

// File: design/gpe_parser.sv
// Sentence parser: tag hunt, comma field split and digit accumulation per byte.
module gpe_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [gpe_pkg::BYTE_W-1:0] rx_byte,
	output logic                       fire,
	output gpe_pkg::gpe_rec_t          rec
);
	import gpe_pkg::*;

	gpe_phase_t           phase_q, phase_d;
	logic [FIELD_W-1:0]   field_q, field_d;
	logic [POS_W-1:0]     pos_q, pos_d;
	gpe_raw_t             acc_q, acc_d;
	logic                 point_q, point_d;
	logic                 ended_q, ended_d;
	gpe_raw_t             lat_q, lat_d;
	gpe_raw_t             lon_q, lon_d;
	logic                 south_q, south_d;
	logic                 west_q, west_d;

	gpe_phase_t           phase_nxt;
	logic [BYTE_W-1:0]    tag_char;
	logic                 digit;
	logic [3:0]           dval;
	logic [POS_W-1:0]     deg_len;
	logic [WHOLE_W+3:0]   whole_ext;
	gpe_raw_t             lat_closed;
	gpe_raw_t             lon_closed;

	always_comb begin
		case (phase_q)
			PH_HUNT_P: begin
				tag_char  = CH_P;
				phase_nxt = PH_HUNT_G1;
			end
			PH_HUNT_G1: begin
				tag_char  = CH_G;
				phase_nxt = PH_HUNT_G2;
			end
			PH_HUNT_G2: begin
				tag_char  = CH_G;
				phase_nxt = PH_HUNT_A;
			end
			PH_HUNT_A: begin
				tag_char  = CH_A;
				phase_nxt = PH_COLLECT;
			end
			default: begin
				tag_char  = CH_STAR;
				phase_nxt = PH_HUNT_P;
			end
		endcase
	end

	assign digit      = rx_byte inside {[CH_0:CH_9]};
	assign dval       = rx_byte[3:0];
	assign deg_len    = (field_q == FLD_LAT) ? LAT_DEG_LEN : LON_DEG_LEN;
	assign whole_ext  = (WHOLE_W+4)'(acc_q.whole) * (WHOLE_W+4)'(10) + (WHOLE_W+4)'(dval);
	assign lat_closed = (field_q == FLD_LAT) ? acc_q : lat_q;
	assign lon_closed = (field_q == FLD_LON) ? acc_q : lon_q;

	assign rec.lat   = lat_closed;
	assign rec.lon   = lon_closed;
	assign rec.south = south_q;
	assign rec.west  = west_q;

	always_comb begin
		phase_d = phase_q;
		field_d = field_q;
		pos_d   = pos_q;
		acc_d   = acc_q;
		point_d = point_q;
		ended_d = ended_q;
		lat_d   = lat_q;
		lon_d   = lon_q;
		south_d = south_q;
		west_d  = west_q;
		fire    = 1'b0;
		if (accept) begin
			if (phase_q != PH_COLLECT) begin
				if (rx_byte == tag_char) begin
					phase_d = phase_nxt;
					if (phase_nxt == PH_COLLECT) begin
						field_d = '0;
						pos_d   = '0;
						acc_d   = '0;
						point_d = 1'b0;
						ended_d = 1'b0;
						lat_d   = '0;
						lon_d   = '0;
						south_d = 1'b0;
						west_d  = 1'b0;
					end
				end else begin
					phase_d = PH_HUNT_P;
				end
			end else if (rx_byte == CH_STAR || rx_byte == CH_COMMA) begin
				// Close the current field and clear the accumulators.
				lat_d   = lat_closed;
				lon_d   = lon_closed;
				pos_d   = '0;
				acc_d   = '0;
				point_d = 1'b0;
				ended_d = 1'b0;
				if (rx_byte == CH_STAR) begin
					fire    = 1'b1;
					phase_d = PH_HUNT_P;
				end else if (field_q != FIELD_MAX) begin
					field_d = field_q + FIELD_W'(1);
				end
			end else begin
				if (field_q == FLD_LAT || field_q == FLD_LON) begin
					// Minutes restart the number right after the degree positions.
					if (pos_q == deg_len)
						ended_d = 1'b0;
					if (!ended_d) begin
						if (pos_q < deg_len) begin
							if (digit)
								acc_d.deg = DEG_W'(acc_q.deg * DEG_W'(10) + DEG_W'(dval));
							else
								ended_d = 1'b1;
						end else if (digit) begin
							if (!point_q) begin
								acc_d.whole = (whole_ext > (WHOLE_W+4)'(WHOLE_MAX)) ?
									WHOLE_MAX : whole_ext[WHOLE_W-1:0];
							end else if (acc_q.cnt < CNT_W'(FRACTION_DIGITS)) begin
								acc_d.frac = FRAC_W'(acc_q.frac * FRAC_W'(10) + FRAC_W'(dval));
								acc_d.cnt  = acc_q.cnt + CNT_W'(1);
							end
						end else if (rx_byte == CH_DOT && !point_q) begin
							point_d = 1'b1;
						end else begin
							ended_d = 1'b1;
						end
					end
				end else if (field_q == FLD_NS && pos_q == '0) begin
					south_d = (rx_byte == CH_S);
				end else if (field_q == FLD_EW && pos_q == '0) begin
					west_d = (rx_byte == CH_W);
				end
				if (pos_q != POS_MAX)
					pos_d = pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT_P;
			field_q <= '0;
			pos_q   <= '0;
			acc_q   <= '0;
			point_q <= 1'b0;
			ended_q <= 1'b0;
			lat_q   <= '0;
			lon_q   <= '0;
			south_q <= 1'b0;
			west_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			field_q <= field_d;
			pos_q   <= pos_d;
			acc_q   <= acc_d;
			point_q <= point_d;
			ended_q <= ended_d;
			lat_q   <= lat_d;
			lon_q   <= lon_d;
			south_q <= south_d;
			west_q  <= west_d;
		end
	end

	a_frac_needs_point: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q.cnt != '0 |-> point_q)
		else $error("fraction digits held without a decimal point");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q.cnt <= CNT_W'(FRACTION_DIGITS) && acc_q.whole <= WHOLE_MAX)
		else $error("minute accumulator beyond its bound");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_COLLECT)
		else $error("parse phase outside the tag hunt and collection");

endmodule

// File: design/gpe_coord_conv.sv
// Coordinate conversion pipeline: raw degrees and minutes to signed 1e-7 degree.
module gpe_coord_conv #(
	parameter int OUT_W = gpe_pkg::LAT_W
) (
	input  logic                     clk,
	input  gpe_pkg::gpe_raw_t        raw,
	input  logic                     neg,
	input  gpe_pkg::gpe_stage_en_t   en,
	output logic signed [OUT_W-1:0]  result
);
	import gpe_pkg::*;

	localparam int MAG_W = OUT_W - 1;

	logic [DEG_W+SCALE_W-1:0]   degp_full;
	logic [WHOLE_W+SCALE_W-1:0] wholep_full;
	logic [FRAC_W+FRACP_W-1:0]  fracp_full;
	logic [NUM_W-1:0]           num_sum;
	logic [M_W+RECIP_W-1:0]     q_full;

	logic [MAG_W-1:0]           degp_s2;
	logic [NUM_W-1:0]           wholep_s2;
	logic [FRACP_W-1:0]         fracp_s2;
	logic                       neg_s2;
	logic [M_W-1:0]             m_s3;
	logic signed [OUT_W-1:0]    degs_s3;
	logic                       neg_s3;
	logic [Q_W-1:0]             q_s4;
	logic signed [OUT_W-1:0]    degs_s4;
	logic                       neg_s4;
	logic signed [OUT_W-1:0]    q_ext;

	assign degp_full   = (DEG_W+SCALE_W)'(raw.deg) * (DEG_W+SCALE_W)'(DEG_SCALE);
	assign wholep_full = (WHOLE_W+SCALE_W)'(raw.whole) * (WHOLE_W+SCALE_W)'(DEG_SCALE);
	assign fracp_full  = (FRAC_W+FRACP_W)'(raw.frac) * (FRAC_W+FRACP_W)'(frac_scale(raw.cnt));
	assign num_sum     = wholep_s2 + NUM_W'(fracp_s2);
	assign q_full      = (M_W+RECIP_W)'(m_s3) * (M_W+RECIP_W)'(RECIP_15);
	assign q_ext       = $signed({{(OUT_W-Q_W){1'b0}}, q_s4});

	always_ff @(posedge clk) begin
		// Products of degrees, whole minutes and scaled fraction.
		if (en.s2) begin
			degp_s2   <= degp_full[MAG_W-1:0];
			wholep_s2 <= wholep_full[NUM_W-1:0];
			fracp_s2  <= fracp_full[FRACP_W-1:0];
			neg_s2    <= neg;
		end
		// Minutes in 1e-7 units, quartered; degree part signed.
		if (en.s3) begin
			m_s3    <= num_sum[NUM_W-1:2];
			degs_s3 <= neg_s2 ? -$signed({1'b0, degp_s2}) : $signed({1'b0, degp_s2});
			neg_s3  <= neg_s2;
		end
		// Divide by 15 through the reciprocal.
		if (en.s4) begin
			q_s4    <= q_full[RECIP_SHIFT +: Q_W];
			degs_s4 <= degs_s3;
			neg_s4  <= neg_s3;
		end
		if (en.s5)
			result <= neg_s4 ? degs_s4 - q_ext : degs_s4 + q_ext;
	end

endmodule

// File: design/gga_position_extractor.sv
// GGA position extractor top level: byte parser feeding two conversion lanes.
// Throughput: one received byte accepted per cycle, every cycle, stalls aside.
// After '*' is accepted, its record passes the record register and stages s2 to s5 to the result beat.
// Stalls on the result side hold the four-stage conversion pipeline; bubbles
// collapse, so bytes keep flowing while a finished result waits to be taken.
// Reset (arst_n, asynchronous, active low) returns the parser to the tag hunt.
module gga_position_extractor (
	input  logic              clk,
	input  logic              arst_n,
	gpe_byte_if.sink          rx,
	gpe_pos_if.source         pos
);
	import gpe_pkg::*;

	logic            accept;
	logic            fire;
	gpe_rec_t        rec;
	gpe_rec_t        rec_s1;
	gpe_stage_en_t   en;

	// Stage occupancy of the record register and the conversion stages.
	logic            v_s1_q;
	logic            v_s2_q;
	logic            v_s3_q;
	logic            v_s4_q;
	logic            v_s5_q;

	// Load permission per stage: a stage takes new contents when empty or
	// when its own contents move on in the same cycle.
	logic            ld1;
	logic            ld2;
	logic            ld3;
	logic            ld4;
	logic            ld5;

	assign ld5 = !v_s5_q || pos.ready;
	assign ld4 = !v_s4_q || ld5;
	assign ld3 = !v_s3_q || ld4;
	assign ld2 = !v_s2_q || ld3;
	assign ld1 = !v_s1_q || ld2;

	// Take a byte whenever the record register could absorb an end mark.
	assign rx.ready = ld1;
	assign accept   = rx.valid && ld1;

	// Advance data registers only when real contents move in.
	assign en.s2 = ld2 && v_s1_q;
	assign en.s3 = ld3 && v_s2_q;
	assign en.s4 = ld4 && v_s3_q;
	assign en.s5 = ld5 && v_s4_q;

	gpe_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx.rx_byte),
		.fire    (fire),
		.rec     (rec)
	);

	// Record register: hold the sentence captured at the end mark.
	always_ff @(posedge clk) begin
		if (ld1 && fire)
			rec_s1 <= rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			v_s4_q <= 1'b0;
			v_s5_q <= 1'b0;
		end else begin
			if (ld1)
				v_s1_q <= fire;
			if (ld2)
				v_s2_q <= v_s1_q;
			if (ld3)
				v_s3_q <= v_s2_q;
			if (ld4)
				v_s4_q <= v_s3_q;
			if (ld5)
				v_s5_q <= v_s4_q;
		end
	end

	// Latitude lane: two degree digits, south negates.
	gpe_coord_conv #(
		.OUT_W (LAT_W)
	) u_lat_conv (
		.clk    (clk),
		.raw    (rec_s1.lat),
		.neg    (rec_s1.south),
		.en     (en),
		.result (pos.latitude)
	);

	// Longitude lane: three degree digits, west negates.
	gpe_coord_conv #(
		.OUT_W (LON_W)
	) u_lon_conv (
		.clk    (clk),
		.raw    (rec_s1.lon),
		.neg    (rec_s1.west),
		.en     (en),
		.result (pos.longitude)
	);

	assign pos.valid = v_s5_q;

	a_record_from_end_mark: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1_q) |-> $past(rx.valid && rx.ready && rx.rx_byte == CH_STAR))
		else $error("sentence record loaded without an end mark beat");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos.valid |-> (pos.latitude <= LAT_LIMIT && pos.latitude >= -LAT_LIMIT))
		else $error("latitude out of range");

	a_lon_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos.valid |-> (pos.longitude <= LON_LIMIT && pos.longitude >= -LON_LIMIT))
		else $error("longitude out of range");

endmodule

// File: tb/gpe_position_checker.sv
// Position checker: follows the byte stream, predicts each position fix and compares the beats.
`timescale 1ns / 1ps
module gpe_position_checker (
	input  logic clk,
	input  logic arst_n,
	gpe_byte_if  rx,
	gpe_pos_if   pos,
	output int   fail_count,
	output int   pending
);
	import gpe_pkg::*;

	typedef struct {
		logic signed [LAT_W-1:0] latitude;
		logic signed [LON_W-1:0] longitude;
	} pos_fix_t;

	pos_fix_t fix_queue[$];
	pos_fix_t oldest_fix;
	int       mismatches = 0;

	// Parser state, kept in step with every accepted byte beat.
	gpe_phase_t         phase;
	logic [FIELD_W-1:0] field_no;
	logic [POS_W-1:0]   char_pos;
	longint unsigned    deg_acc, whole_acc, frac_acc, lat_mag, lon_mag;
	int unsigned        frac_cnt;
	logic               dot_seen, num_done, south, west;

	task automatic clear_number();
		char_pos  = '0;
		deg_acc   = 0;
		whole_acc = 0;
		frac_acc  = 0;
		frac_cnt  = 0;
		dot_seen  = 1'b0;
		num_done  = 1'b0;
	endtask

	// Degrees and minutes to units of 1e-7 degree, minutes rounded down.
	function automatic longint unsigned to_fixed();
		longint unsigned min_scaled;
		min_scaled = whole_acc * (64'd10 ** FRACTION_DIGITS)
			+ frac_acc * (64'd10 ** (FRACTION_DIGITS - frac_cnt));
		return deg_acc * 64'd10_000_000
			+ min_scaled * (64'd10 ** (7 - FRACTION_DIGITS)) / 64'd60;
	endfunction

	task automatic close_field();
		if (field_no == FLD_LAT)
			lat_mag = to_fixed() & 64'h7FFF_FFFF;
		else if (field_no == FLD_LON)
			lon_mag = to_fixed() & 64'h3_FFFF_FFFF;
		clear_number();
	endtask

	task automatic take_number_char(logic [BYTE_W-1:0] c, logic [POS_W-1:0] deg_len);
		logic            is_digit;
		longint unsigned d, w;
		is_digit = (c >= CH_0) && (c <= CH_9);
		d = is_digit ? c - CH_0 : 0;
		// The minutes always start right after the degree positions.
		if (char_pos == deg_len)
			num_done = 1'b0;
		if (!num_done) begin
			if (char_pos < deg_len) begin
				if (is_digit)
					deg_acc = deg_acc * 10 + d;
				else
					num_done = 1'b1;
			end else if (is_digit) begin
				if (!dot_seen) begin
					w = whole_acc * 10 + d;
					whole_acc = (w > WHOLE_MAX) ? WHOLE_MAX : w;
				end else if (frac_cnt < FRACTION_DIGITS) begin
					frac_acc = frac_acc * 10 + d;
					frac_cnt++;
				end
			end else if (c == CH_DOT && !dot_seen) begin
				dot_seen = 1'b1;
			end else begin
				num_done = 1'b1;
			end
		end
	endtask

	task automatic parse_rx_byte(logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] want;
		pos_fix_t          fix;
		if (phase != PH_COLLECT) begin
			case (phase)
				PH_HUNT_P: want = CH_P;
				PH_HUNT_A: want = CH_A;
				default:   want = CH_G;
			endcase
			if (c != want) begin
				phase = PH_HUNT_P;
			end else if (phase != PH_HUNT_A) begin
				phase = gpe_phase_t'(phase + 1);
			end else begin
				phase    = PH_COLLECT;
				field_no = '0;
				clear_number();
				lat_mag  = 0;
				lon_mag  = 0;
				south    = 1'b0;
				west     = 1'b0;
			end
		end else if (c == CH_STAR) begin
			close_field();
			fix.latitude  = LAT_W'(south ? 64'd0 - lat_mag : lat_mag);
			fix.longitude = LON_W'(west ? 64'd0 - lon_mag : lon_mag);
			fix_queue.push_back(fix);
			phase = PH_HUNT_P;
		end else if (c == CH_COMMA) begin
			close_field();
			if (field_no != FIELD_MAX)
				field_no++;
		end else begin
			if (field_no == FLD_LAT)
				take_number_char(c, LAT_DEG_LEN);
			else if (field_no == FLD_LON)
				take_number_char(c, LON_DEG_LEN);
			else if (field_no == FLD_NS && char_pos == '0)
				south = (c == CH_S);
			else if (field_no == FLD_EW && char_pos == '0)
				west = (c == CH_W);
			if (char_pos != POS_MAX)
				char_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase    = PH_HUNT_P;
			field_no = '0;
			clear_number();
			lat_mag  = 0;
			lon_mag  = 0;
			south    = 1'b0;
			west     = 1'b0;
			fix_queue.delete();
			pending  <= 0;
		end else begin
			if (pos.valid && pos.ready) begin
				if (fix_queue.size() == 0) begin
					mismatches++;
					$display("%0t: position beat with none expected, actual lat %0d lon %0d",
						$time, pos.latitude, pos.longitude);
				end else begin
					oldest_fix = fix_queue.pop_front();
					if (pos.latitude !== oldest_fix.latitude) begin
						mismatches++;
						$display("%0t: latitude mismatch, expected %0d, actual %0d",
							$time, oldest_fix.latitude, pos.latitude);
					end
					if (pos.longitude !== oldest_fix.longitude) begin
						mismatches++;
						$display("%0t: longitude mismatch, expected %0d, actual %0d",
							$time, oldest_fix.longitude, pos.longitude);
					end
				end
			end
			if (rx.valid && rx.ready)
				parse_rx_byte(rx.rx_byte);
			pending <= fix_queue.size();
		end
		fail_count <= mismatches;
	end

endmodule

// File: tb/gga_position_extractor_test.sv
// Testbench top for the GGA position extractor: sentence stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module gga_position_extractor_test;
	import gpe_pkg::*;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Failure count and fixes still owed, both kept by the checker.
	int fail_count;
	int pending;

	// Idle control: a quiet side never idles, so back-to-back stretches occur.
	bit tx_quiet  = 1'b0;
	bit pos_quiet = 1'b0;

	// Byte beats taken so far set the length of the random part.
	int byte_beats = 0;

	gpe_byte_if rx_ch();
	gpe_pos_if  pos_ch();

	gga_position_extractor u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.pos    (pos_ch)
	);

	gpe_position_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.pos        (pos_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// Hard stop well beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: draw a stall before every beat, then hold ready until a beat is taken.
	initial begin
		int stall;
		pos_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pos_quiet ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				pos_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pos_ch.ready <= 1'b1;
			@(posedge clk);
			while (pos_ch.valid !== 1'b1)
				@(posedge clk);
		end
	end

	// Offer one byte after a random gap and hold it until the beat is taken.
	// Valid stays high between back-to-back bytes; it drops only for a gap.
	task automatic send_byte(logic [BYTE_W-1:0] b);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (rx_ch.ready !== 1'b1)
			@(posedge clk);
		byte_beats++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [BYTE_W-1:0] digit_char();
		return CH_0 + BYTE_W'($urandom_range(0, 9));
	endfunction

	// Any byte that does not split the sentence, used to end a number or spoil a hemisphere.
	function automatic logic [BYTE_W-1:0] junk_char();
		logic [BYTE_W-1:0] c;
		c = BYTE_W'($urandom_range(0, 255));
		return (c == CH_COMMA || c == CH_STAR) ? CH_DOT : c;
	endfunction

	task automatic send_digits(int n);
		repeat (n) send_byte(digit_char());
	endtask

	// Latitude or longitude field; mostly well formed, sometimes spoilt or empty.
	task automatic send_coord(int deg_len);
		case ($urandom_range(0, 9))
			0: ;
			1: repeat ($urandom_range(1, 18)) send_byte(BYTE_W'($urandom_range(0, 255)));
			2: begin
				// Degree part cut short by a stray character.
				send_digits($urandom_range(0, deg_len - 1));
				send_byte(junk_char());
				send_digits($urandom_range(0, 6));
				if ($urandom_range(0, 1) != 0)
					send_byte(CH_DOT);
				send_digits($urandom_range(0, 8));
			end
			default: begin
				send_digits(deg_len);
				send_digits(($urandom_range(0, 2) != 0) ? 2 : $urandom_range(0, 4));
				if ($urandom_range(0, 4) != 0) begin
					send_byte(CH_DOT);
					send_digits($urandom_range(0, 9));
				end
				if ($urandom_range(0, 7) == 0)
					send_byte(junk_char());
			end
		endcase
	endtask

	// Hemisphere field: only its first character should count.
	task automatic send_hemisphere(logic [BYTE_W-1:0] neg, string plus);
		case ($urandom_range(0, 6))
			0: ;
			1: send_byte(junk_char());
			2: begin
				send_byte(neg);
				send_text(plus);
			end
			3: begin
				send_text(plus);
				send_byte(neg);
			end
			4: send_text(plus);
			default: send_byte(neg);
		endcase
	endtask

	// One GGA sentence with random content; without its end mark the next
	// sentence runs on into the trailing fields.
	task automatic send_sentence(bit with_end);
		if ($urandom_range(0, 3) == 0)
			send_text("$GP");
		send_text("PGGA");
		if ($urandom_range(0, 5) == 0)
			send_byte(junk_char());
		send_byte(CH_COMMA);
		send_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0);
		send_byte(CH_COMMA);
		send_coord(2);
		send_byte(CH_COMMA);
		send_hemisphere(CH_S, "N");
		send_byte(CH_COMMA);
		send_coord(3);
		send_byte(CH_COMMA);
		send_hemisphere(CH_W, "E");
		// Trailing fields, now and then enough to saturate the field count.
		repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0) begin
			send_byte(CH_COMMA);
			send_digits($urandom_range(0, 3));
		end
		if (with_end)
			send_byte(CH_STAR);
		if (with_end && $urandom_range(0, 3) == 0)
			send_text("5A\r\n");
	endtask

	// Bytes seen while hunting: random rubbish and tags that fall apart.
	task automatic send_noise();
		case ($urandom_range(0, 2))
			0: repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
			1: send_text("PGG");
			default: send_text("PPGA");
		endcase
	endtask

	// Hold the byte side until every fix owed has been taken.
	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("PGGA,123519,4807.038,N,01131.000,E*");
		// Largest digits: whole minutes saturate, fraction digits truncate, both negative.
		send_text("PGGA,,9999999.9999999,S,99999999.99999999,W*");
		send_text("PGGA,,0000.00000,N,00000.00000,E*");
		// End mark straight after the tag, then all fields empty.
		send_text("PGGA*");
		send_text("PGGA,,,,,,,,,,*");
		// Tags broken by a repeated or stray byte; the breaking byte is not retried.
		send_text("PPGGA,,1234.5,S*");
		send_text("PGGPGGA,,1234.5,S*");
		// Degree part ended early, second point, two-letter hemispheres.
		send_text("PGGA,X,4.0730.5,SN,1-2030.25.5,WE*");
		send_text("PGGA,,1230.5.7x9,s,12345.6 9,w*");
		// Long fields push the character position to saturation.
		send_text("PGGA,,12345678901234567890.1,S,0000000000000000000,W*");
		send_text("PGGA,,");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("12.5,S,");
		send_byte(8'hFF);
		send_byte(CH_STAR);
		// A tag inside a sentence is plain field content.
		send_text("PGGA,7,PGGA,5000.0,N*");
		drain();

		// Random part: mostly well formed sentences, some broken, some noise.
		while (byte_beats < 950) begin
			tx_quiet  = ($urandom_range(0, 3) == 0);
			pos_quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0:       send_noise();
				1:       send_sentence(1'b0);
				default: send_sentence(1'b1);
			endcase
			if ($urandom_range(0, 11) == 0)
				drain();
		end

		// Let the last fixes come out, then wait on for stray beats.
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
